// ===== hdl/prle_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prle_pkg : shared types and constants for the point run-length encoder
// Record layout, the record push bundle, and the tolerance comparison.
// ---------------------------------------------------------------------------
package prle_pkg;

  localparam int unsigned PRLE_OUT_DEPTH = 4;
  localparam logic [31:0] PRLE_COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic [15:0] PRLE_TOL_RESET = 16'd7;

  // One run record as it leaves the block
  typedef struct packed {
    logic        [31:0] count;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic        [7:0]  red;
    logic        [7:0]  green;
    logic        [7:0]  blue;
    logic               last;
    logic        [31:0] total;
  } prle_rec_t;

  // Records produced by one point: n is 0, 1 or 2, rec0 goes out first
  typedef struct packed {
    logic [1:0] n;
    prle_rec_t  rec0;
    prle_rec_t  rec1;
  } prle_push_t;

  // True when |a - b| < tol, with a and b signed 32-bit
  function automatic logic coord_close(input logic signed [31:0] a,
                                       input logic signed [31:0] b,
                                       input logic [15:0] tol);
    logic signed [32:0] d;
    logic [32:0]        mag;
    d   = {a[31], a} - {b[31], b};
    mag = d[32] ? (~d + 33'd1) : d;
    return mag < {17'd0, tol};
  endfunction

endpackage

// ===== hdl/prle_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prle_core : run tracking and record generation
// Holds the open run and counters, compares each accepted point against the
// run's first point and builds the records that the point closes.
// ---------------------------------------------------------------------------
module prle_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic signed [31:0]  coord_x,
  input  logic signed [31:0]  coord_y,
  input  logic signed [31:0]  coord_z,
  input  logic [7:0]          color_red,
  input  logic [7:0]          color_green,
  input  logic [7:0]          color_blue,
  input  logic                frame_end,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  output prle_pkg::prle_push_t push
);
  import prle_pkg::*;

  logic [15:0]        tol_r;
  logic               open_r,  open_nxt;
  logic signed [31:0] hx_r,    hx_nxt;
  logic signed [31:0] hy_r,    hy_nxt;
  logic signed [31:0] hz_r,    hz_nxt;
  logic [23:0]        hc_r,    hc_nxt;
  logic [31:0]        rc_r,    rc_nxt;
  logic [31:0]        pc_r,    pc_nxt;

  logic        match;
  logic        closed;
  logic [23:0] color;
  logic [31:0] run_cnt;
  prle_rec_t   closed_rec;
  prle_rec_t   final_rec;

  assign color = {color_red, color_green, color_blue};

  // Compare against the run's first point
  always_comb begin
    match = coord_close(hx_r, coord_x, tol_r) &&
            coord_close(hy_r, coord_y, tol_r) &&
            coord_close(hz_r, coord_z, tol_r) &&
            (color == hc_r);
    closed = open_r && !(match && (rc_r != PRLE_COUNT_MAX));
  end

  // Work out the run state after this point
  always_comb begin
    pc_nxt = (pc_r == PRLE_COUNT_MAX) ? pc_r : pc_r + 32'd1;
    if (!open_r || closed) begin
      hx_nxt  = coord_x;
      hy_nxt  = coord_y;
      hz_nxt  = coord_z;
      hc_nxt  = color;
      run_cnt = 32'd1;
    end else begin
      hx_nxt  = hx_r;
      hy_nxt  = hy_r;
      hz_nxt  = hz_r;
      hc_nxt  = hc_r;
      run_cnt = rc_r + 32'd1;
    end
    rc_nxt   = run_cnt;
    open_nxt = 1'b1;
    // Frame end drops the run and restarts the cloud count
    if (frame_end) begin
      open_nxt = 1'b0;
      hx_nxt   = '0;
      hy_nxt   = '0;
      hz_nxt   = '0;
      hc_nxt   = '0;
      rc_nxt   = '0;
    end
  end

  // Build the closed and final records
  always_comb begin
    closed_rec.count = rc_r;
    closed_rec.x     = hx_r;
    closed_rec.y     = hy_r;
    closed_rec.z     = hz_r;
    closed_rec.red   = hc_r[23:16];
    closed_rec.green = hc_r[15:8];
    closed_rec.blue  = hc_r[7:0];
    closed_rec.last  = 1'b0;
    closed_rec.total = '0;

    final_rec.count  = run_cnt;
    final_rec.x      = (!open_r || closed) ? coord_x : hx_r;
    final_rec.y      = (!open_r || closed) ? coord_y : hy_r;
    final_rec.z      = (!open_r || closed) ? coord_z : hz_r;
    final_rec.red    = (!open_r || closed) ? color_red   : hc_r[23:16];
    final_rec.green  = (!open_r || closed) ? color_green : hc_r[15:8];
    final_rec.blue   = (!open_r || closed) ? color_blue  : hc_r[7:0];
    final_rec.last   = 1'b1;
    final_rec.total  = pc_nxt;

    push.n    = {1'b0, closed} + {1'b0, frame_end};
    push.rec0 = closed ? closed_rec : final_rec;
    push.rec1 = final_rec;
  end

  // Hold tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= PRLE_TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_data;
    end
  end

  // Advance run state on each accepted point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      hx_r   <= '0;
      hy_r   <= '0;
      hz_r   <= '0;
      hc_r   <= '0;
      rc_r   <= '0;
      pc_r   <= '0;
    end else if (accept) begin
      open_r <= open_nxt;
      hx_r   <= hx_nxt;
      hy_r   <= hy_nxt;
      hz_r   <= hz_nxt;
      hc_r   <= hc_nxt;
      rc_r   <= rc_nxt;
      pc_r   <= frame_end ? 32'd0 : pc_nxt;
    end
  end

endmodule

// ===== hdl/prle_outq.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prle_outq : record output queue
// Small register queue that takes up to two records a cycle and hands one
// record a cycle to the output channel while out_stall is low.
// ---------------------------------------------------------------------------
module prle_outq #(
  parameter int unsigned DEPTH = prle_pkg::PRLE_OUT_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_en,
  input  prle_pkg::prle_push_t push,
  input  logic                 out_stall,
  output logic                 out_valid,
  output prle_pkg::prle_rec_t  out_rec,
  output logic                 room
);
  import prle_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + PW'(1);
  endfunction

  prle_rec_t     mem [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;
  logic [1:0]    n_push;

  assign n_push    = push_en ? push.n : 2'd0;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_rec   = mem[rd_r];
  assign room      = (cnt_r <= ROOM_MAX);

  // Advance pointers and fill level
  always_comb begin
    case (n_push)
      2'd1:    wr_nxt = ptr_inc(wr_r);
      2'd2:    wr_nxt = ptr_inc(ptr_inc(wr_r));
      default: wr_nxt = wr_r;
    endcase
    rd_nxt  = pop ? ptr_inc(rd_r) : rd_r;
    cnt_nxt = cnt_r + CW'(n_push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store records
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_r] <= push.rec0;
    end
    if (n_push == 2'd2) begin
      mem[ptr_inc(wr_r)] <= push.rec1;
    end
  end

endmodule

// ===== hdl/point_run_length_encoder.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// point_run_length_encoder : run-length encoder for colored 3D points
// Groups consecutive points that stay within a coordinate tolerance of the
// run's first point and share its color, and emits one record per run.
// ---------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall  | point x y z, r g b, frame_end
//  out_    | output    | out_valid/out_stall  | run record, last flag, total
//  cfg_    | input     | cfg_valid/cfg_ready  | coord_tolerance (16 bit)
//
//  One point is accepted per cycle while in_stall is low; its records
//  enter a 4-entry output queue at the accepting edge and leave it one
//  per cycle while out_stall is low. A point that closes a run at frame
//  end yields two records. in_stall rises while fewer than two queue
//  entries are free. Synchronous active-low reset clears the run, counters
//  and the queue and sets the tolerance to 7. cfg_ready is always high.
// ---------------------------------------------------------------------------
module point_run_length_encoder #(
  parameter int unsigned OUT_DEPTH = prle_pkg::PRLE_OUT_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  input  logic [7:0]         in_color_red,
  input  logic [7:0]         in_color_green,
  input  logic [7:0]         in_color_blue,
  input  logic               in_frame_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_run_count,
  output logic signed [31:0] out_run_x,
  output logic signed [31:0] out_run_y,
  output logic signed [31:0] out_run_z,
  output logic [7:0]         out_run_red,
  output logic [7:0]         out_run_green,
  output logic [7:0]         out_run_blue,
  output logic               out_last_run,
  output logic [31:0]        out_total_points,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import prle_pkg::*;

  logic       accept;
  logic       room;
  prle_push_t push;
  prle_rec_t  rec;

  assign in_stall  = !room;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  prle_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .coord_x     (in_coord_x),
    .coord_y     (in_coord_y),
    .coord_z     (in_coord_z),
    .color_red   (in_color_red),
    .color_green (in_color_green),
    .color_blue  (in_color_blue),
    .frame_end   (in_frame_end),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .push        (push)
  );

  prle_outq #(.DEPTH(OUT_DEPTH)) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (accept),
    .push      (push),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_rec   (rec),
    .room      (room)
  );

  // Unpack the head record onto the ports
  assign out_run_count    = rec.count;
  assign out_run_x        = rec.x;
  assign out_run_y        = rec.y;
  assign out_run_z        = rec.z;
  assign out_run_red      = rec.red;
  assign out_run_green    = rec.green;
  assign out_run_blue     = rec.blue;
  assign out_last_run     = rec.last;
  assign out_total_points = rec.total;

endmodule

// ===== hdl/prle_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prle_checker : port-level checks for the point run-length encoder
// Watches the top-level ports and flags record and handshake errors.
// ---------------------------------------------------------------------------
module prle_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [31:0]        out_run_count,
  input logic signed [31:0] out_run_x,
  input logic signed [31:0] out_run_y,
  input logic signed [31:0] out_run_z,
  input logic [7:0]         out_run_red,
  input logic [7:0]         out_run_green,
  input logic [7:0]         out_run_blue,
  input logic               out_last_run,
  input logic [31:0]        out_total_points
);

  // Reset empties the output queue
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Hold a stalled record
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_run_count) &&
      $stable(out_run_x) && $stable(out_run_y) && $stable(out_run_z) &&
      $stable(out_run_red) && $stable(out_run_green) && $stable(out_run_blue) &&
      $stable(out_last_run) && $stable(out_total_points))
    else $error("stalled record changed");

  // Every run holds at least one point
  a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_run_count != 32'd0)
    else $error("empty run record");

  // Only the last record carries the cloud total
  a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_run |-> out_total_points == 32'd0)
    else $error("total on a record that is not last");

  // The cloud holds at least the points of its final run
  a_total_cover: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_run |-> out_total_points >= out_run_count)
    else $error("cloud total below final run count");

endmodule

bind point_run_length_encoder prle_checker u_prle_checker (.*);

// ===== tb/point_run_length_encoder_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// point_run_length_encoder_tb : self-checking bench for the point RLE block
// Drives colored points under random valid gaps and output stalls, predicts
// the run records of every accepted point and compares each whole record.
// Covers tolerance edges, color mismatches, frame ends, coordinate extremes,
// several tolerance settings and a long output hold-off.
// ---------------------------------------------------------------------------
module point_run_length_encoder_tb;
  import prle_pkg::*;

  localparam int STALL_PCT       = 13;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 4;
  localparam int MAX_REPORTS     = 10;
  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               fend;
  } point_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_coord_x = '0;
  logic signed [31:0] in_coord_y = '0;
  logic signed [31:0] in_coord_z = '0;
  logic [7:0]         in_color_red = '0;
  logic [7:0]         in_color_green = '0;
  logic [7:0]         in_color_blue = '0;
  logic               in_frame_end = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        out_run_count;
  logic signed [31:0] out_run_x;
  logic signed [31:0] out_run_y;
  logic signed [31:0] out_run_z;
  logic [7:0]         out_run_red;
  logic [7:0]         out_run_green;
  logic [7:0]         out_run_blue;
  logic               out_last_run;
  logic [31:0]        out_total_points;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_data = '0;

  // Encoder state as predicted by the bench
  logic [15:0] tolerance = PRLE_TOL_RESET;
  bit          run_held = 1'b0;
  point_t      held_point = '0;
  logic [31:0] held_count = '0;
  logic [31:0] cloud_points = '0;
  prle_rec_t   expected_runs[$];

  int  fails = 0;
  int  points_sent = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  bit  hold_request = 1'b0;
  bit  steady = 1'b0;
  bit  offering = 1'b0;

  point_run_length_encoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_coord_z       (in_coord_z),
    .in_color_red     (in_color_red),
    .in_color_green   (in_color_green),
    .in_color_blue    (in_color_blue),
    .in_frame_end     (in_frame_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_run_count    (out_run_count),
    .out_run_x        (out_run_x),
    .out_run_y        (out_run_y),
    .out_run_z        (out_run_z),
    .out_run_red      (out_run_red),
    .out_run_green    (out_run_green),
    .out_run_blue     (out_run_blue),
    .out_last_run     (out_last_run),
    .out_total_points (out_total_points),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic bit within_tol(logic signed [31:0] a, logic signed [31:0] b,
                                    logic [15:0] tol);
    longint gap;
    gap = longint'(a) - longint'(b);
    if (gap < 0) gap = -gap;
    return gap < longint'(tol);
  endfunction

  function automatic prle_rec_t run_record(bit last);
    prle_rec_t r;
    r.count = held_count;
    r.x     = held_point.x;
    r.y     = held_point.y;
    r.z     = held_point.z;
    r.red   = held_point.red;
    r.green = held_point.green;
    r.blue  = held_point.blue;
    r.last  = last;
    r.total = last ? cloud_points : 32'd0;
    return r;
  endfunction

  // Advance the run state by one point and queue the records it closes
  task automatic encode_point(point_t p);
    bit joins;
    if (cloud_points != PRLE_COUNT_MAX) cloud_points++;
    if (run_held) begin
      joins = within_tol(held_point.x, p.x, tolerance) &&
              within_tol(held_point.y, p.y, tolerance) &&
              within_tol(held_point.z, p.z, tolerance) &&
              {p.red, p.green, p.blue} == {held_point.red, held_point.green, held_point.blue};
      if (joins && held_count != PRLE_COUNT_MAX) begin
        held_count++;
      end else begin
        expected_runs.insert(expected_runs.size(), run_record(1'b0));
        run_held = 1'b0;
      end
    end
    if (!run_held) begin
      run_held   = 1'b1;
      held_point = p;
      held_count = 32'd1;
    end
    // Flush the cloud and return to idle
    if (p.fend) begin
      expected_runs.insert(expected_runs.size(), run_record(1'b1));
      run_held     = 1'b0;
      held_point   = '0;
      held_count   = '0;
      cloud_points = '0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  function automatic string rec_text(prle_rec_t r);
    return $sformatf("count=%0d x=%0d y=%0d z=%0d rgb=%0d/%0d/%0d last=%0d total=%0d",
                     r.count, r.x, r.y, r.z, r.red, r.green, r.blue, r.last, r.total);
  endfunction

  task automatic note_failure(string msg);
    fails++;
    if (fails <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  // Compare each record transaction, then track config and point transactions
  always @(posedge clk) begin : check_runs
    prle_rec_t got;
    prle_rec_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_run_count, out_run_x, out_run_y, out_run_z, out_run_red,
               out_run_green, out_run_blue, out_last_run, out_total_points};
        if (expected_runs.size() == 0) begin
          note_failure({"run record with none expected: ", rec_text(got)});
        end else begin
          want = expected_runs.pop_front();
          if (got !== want)
            note_failure({"run record mismatch\n  expected ", rec_text(want),
                          "\n  actual   ", rec_text(got)});
        end
      end
      if (cfg_valid && cfg_ready) tolerance = cfg_data;
      if (in_valid && !in_stall)
        encode_point({in_coord_x, in_coord_y, in_coord_z, in_color_red,
                      in_color_green, in_color_blue, in_frame_end});
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stalls, or a counted hold-off on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_OFF_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < STALL_PCT);
    end
  end

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  task automatic withdraw();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Offer one point at a falling edge and hold it until accepted
  task automatic send_point(point_t p);
    while (!steady && $urandom_range(99) < STALL_PCT) begin
      withdraw();
      @(negedge clk);
    end
    {in_coord_x, in_coord_y, in_coord_z, in_color_red, in_color_green,
     in_color_blue, in_frame_end} <= p;
    in_valid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    points_sent++;
  endtask

  task automatic wait_idle();
    withdraw();
    @(negedge clk);
    while (expected_runs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_tolerance(logic [15:0] value);
    withdraw();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Change flags read by the receiver only at a rising edge
  task automatic set_steady(bit on);
    withdraw();
    @(posedge clk);
    steady = on;
    @(negedge clk);
  endtask

  task automatic start_hold_off();
    withdraw();
    @(posedge clk);
    hold_request = 1'b1;
    @(negedge clk);
  endtask

  function automatic point_t pt(logic signed [31:0] x, logic signed [31:0] y,
                                logic signed [31:0] z, logic [7:0] r, logic [7:0] g,
                                logic [7:0] b, logic fend);
    return {x, y, z, r, g, b, fend};
  endfunction

  function automatic logic signed [31:0] random_coord();
    case ($urandom_range(7))
      0, 1, 2, 3: return $urandom;
      4:          return COORD_MAX - $urandom_range(3);
      5:          return COORD_MIN + $urandom_range(3);
      default:    return int'($urandom_range(4000)) - 2000;
    endcase
  endfunction

  function automatic point_t random_point();
    return pt(random_coord(), random_coord(), random_coord(), 8'($urandom_range(255)),
              8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
  endfunction

  function automatic int offset(int unsigned reach);
    return int'($urandom_range(2 * reach)) - int'(reach);
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Default tolerance: boundaries, colors, frame ends and coordinate extremes
  task automatic test_directed_points();
    // lone point closed by frame end
    send_point(pt(0, 0, 0, 10, 20, 30, 1));
    // differences of 6 join, 7 does not
    send_point(pt(0, 0, 0, 10, 20, 30, 0));
    send_point(pt(6, -6, 6, 10, 20, 30, 0));
    send_point(pt(-6, 6, -6, 10, 20, 30, 0));
    send_point(pt(7, 0, 0, 10, 20, 30, 0));
    send_point(pt(13, 0, 0, 10, 20, 30, 0));
    send_point(pt(14, 0, 0, 10, 20, 30, 0));
    // matching point at frame end
    send_point(pt(14, 0, 0, 10, 20, 30, 1));
    // compare against the run's first point, not the previous one
    send_point(pt(100, 0, 0, 10, 20, 30, 0));
    send_point(pt(105, 0, 0, 10, 20, 30, 0));
    send_point(pt(110, 0, 0, 10, 20, 30, 0));
    // mismatch at frame end yields two records
    send_point(pt(200, 0, 0, 10, 20, 30, 1));
    // one color channel differs each time
    send_point(pt(0, 0, 0, 10, 20, 30, 0));
    send_point(pt(0, 0, 0, 11, 20, 30, 0));
    send_point(pt(0, 0, 0, 11, 21, 30, 0));
    send_point(pt(0, 0, 0, 11, 21, 31, 1));
    // extremes: near points join, wrapped ones do not
    send_point(pt(COORD_MAX, COORD_MIN, COORD_MAX, 255, 255, 255, 0));
    send_point(pt(COORD_MAX - 6, COORD_MIN + 6, COORD_MAX - 6, 255, 255, 255, 0));
    send_point(pt(COORD_MIN, COORD_MAX, COORD_MIN, 255, 255, 255, 0));
    send_point(pt(COORD_MIN, COORD_MAX, COORD_MIN, 0, 0, 0, 0));
    send_point(pt(COORD_MIN + 6, COORD_MAX - 6, COORD_MIN, 0, 0, 0, 1));
    wait_idle();
  endtask

  // Zero, full-scale and unit tolerance
  task automatic test_tolerance_limits();
    write_tolerance(16'd0);
    send_point(pt(5, 5, 5, 1, 2, 3, 0));
    send_point(pt(5, 5, 5, 1, 2, 3, 0));
    send_point(pt(5, 5, 5, 1, 2, 3, 1));
    wait_idle();
    write_tolerance(16'hFFFF);
    send_point(pt(0, 0, 0, 4, 5, 6, 0));
    send_point(pt(65534, -65534, 65534, 4, 5, 6, 0));
    send_point(pt(-65535, 0, 0, 4, 5, 6, 0));
    send_point(pt(-1, 0, 0, 4, 5, 6, 1));
    wait_idle();
    write_tolerance(16'd1);
    send_point(pt(1, 1, 1, 7, 8, 9, 0));
    send_point(pt(1, 1, 1, 7, 8, 9, 0));
    send_point(pt(2, 1, 1, 7, 8, 9, 1));
    wait_idle();
  endtask

  // Hold the output off long enough for the block to stall its input
  task automatic test_output_hold_off();
    point_t p;
    write_tolerance(16'd0);
    start_hold_off();
    for (int i = 0; i < 40; i++) begin
      p      = random_point();
      p.fend = (i == 39);
      send_point(p);
    end
    wait_idle();
  endtask

  // Clouds of runs near random bases, with noise and broken runs mixed in
  task automatic test_random_clouds(int goal, logic [15:0] tol, bit no_gaps);
    int          stop;
    int unsigned len;
    int unsigned reach;
    point_t      base;
    point_t      p;
    write_tolerance(tol);
    set_steady(no_gaps);
    stop = points_sent + goal;
    while (points_sent < stop) begin
      if ($urandom_range(9) == 0) begin
        p      = random_point();
        p.fend = ($urandom_range(3) == 0);
        send_point(p);
      end else begin
        base = random_point();
        len  = ($urandom_range(7) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          reach = (tol == 0) ? 0 : tol - 1;
          if ($urandom_range(9) == 0) reach = tol + 2;
          p   = base;
          p.x = base.x + offset(reach);
          p.y = base.y + offset(reach);
          p.z = base.z + offset(reach);
          // break the run with a single flipped color bit now and then
          if ($urandom_range(19) == 0) begin
            case ($urandom_range(2))
              0:       p.red   ^= 8'(1 << $urandom_range(7));
              1:       p.green ^= 8'(1 << $urandom_range(7));
              default: p.blue  ^= 8'(1 << $urandom_range(7));
            endcase
          end
          p.fend = (i == len - 1) && ($urandom_range(3) == 0);
          send_point(p);
        end
      end
    end
    // close the last cloud before the next setting
    p      = random_point();
    p.fend = 1'b1;
    send_point(p);
    if (no_gaps) set_steady(1'b0);
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_points();
    test_tolerance_limits();
    test_output_hold_off();
    test_random_clouds(245, 16'd7, 1'b0);
    test_random_clouds(245, 16'd0, 1'b0);
    test_random_clouds(245, 16'hFFFF, 1'b1);
    test_random_clouds(245, 16'd1, 1'b0);
    test_random_clouds(245, 16'($urandom_range(8, 64)), 1'b0);
    test_random_clouds(245, 16'($urandom_range(65535)), 1'b0);

    if (expected_runs.size() != 0) note_failure("run records still expected at the end");
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
